// ----- hdl/rmfrq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmfrq_pkg
// Shared types and constants for the range query.
// ----------------------------------------------------------------------------
package rmfrq_pkg;

  localparam int unsigned MaxElementsDefault = 65536;
  localparam int unsigned ValueWidthDefault  = 32;
  localparam int unsigned InValueWidth       = 32;
  localparam int unsigned InIndexWidth       = 16;
  localparam int unsigned OutRunWidth        = 17;

  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef struct packed {
    logic                           func;
    logic signed [InValueWidth-1:0] value;
    logic                           last;
    logic [InIndexWidth-1:0]        left_index;
    logic [InIndexWidth-1:0]        right_index;
  } in_item_t;

  typedef struct packed {
    logic [OutRunWidth-1:0] max_frequency;
    logic                   valid_res;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle,
    StLoad,
    StBWalk,
    StBLeaf,
    StBRet,
    StBRdL,
    StBRdR,
    StBWr,
    StQWalk,
    StQMerge,
    StQRet
  } state_e;

endpackage

// ----- hdl/range_most_frequent_run_query_top.sv -----
// ----------------------------------------------------------------------------
// range_most_frequent_run_query_top
// Longest run of equal values over a range of a loaded sorted array.
// ----------------------------------------------------------------------------
// A load is accepted in StIdle and written to the element store in the
// next cycle. The load flagged last then builds the tree with a depth-first
// walk over a small ancestor stack, with input held off: a leaf is written
// in StBLeaf, and an inner node reads its children in turn (StBRdL, StBRdR)
// through the single read port of the node memory, then writes the merged
// run in StBWr. A query walks the tree from the root, descending into partly
// covered nodes, merging covered ones and skipping disjoint ones; its result
// shows the cycle after the walk ends. A query that cannot be answered
// returns its result the cycle after its transfer. Input is refused while a
// result waits. Every node is written in an earlier state than the one that
// reads it back, so the node memory needs no forwarding.
module range_most_frequent_run_query_top
  import rmfrq_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MaxElementsDefault,
  parameter int unsigned VALUE_WIDTH  = ValueWidthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned LW  = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW  = LW + 1;
  localparam int unsigned NW  = LW + 2;
  localparam int unsigned DW  = 2 * VALUE_WIDTH + 3 * CW;
  localparam int unsigned SD  = CW;
  localparam int unsigned SPW = $clog2(SD);

  typedef struct packed {
    logic                   empty;
    logic [VALUE_WIDTH-1:0] first;
    logic [VALUE_WIDTH-1:0] last;
    logic [CW-1:0]          span;
    logic [CW-1:0]          lead;
    logic [CW-1:0]          trail;
    logic [CW-1:0]          best;
  } run_t;

  typedef struct packed {
    logic [NW-1:0] node;
    logic [CW-1:0] lo;
    logic [CW-1:0] hi;
    logic          post;
  } frame_t;

  function automatic logic [CW-1:0] umax(logic [CW-1:0] a, logic [CW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic run_t combine(run_t a, run_t b);
    run_t r;
    logic [CW-1:0] join_len;
    r = a;
    join_len = a.trail + b.lead;
    if (a.empty) begin
      r = b;
    end else if (!b.empty) begin
      r.empty = 1'b0;
      r.first = a.first;
      r.last  = b.last;
      r.span  = a.span + b.span;
      r.lead  = a.lead;
      r.trail = b.trail;
      r.best  = umax(a.best, b.best);
      if (a.last == b.first) begin
        if (a.lead == a.span) r.lead = a.span + b.lead;
        if (b.trail == b.span) r.trail = a.trail + b.span;
        r.best = umax(r.best, join_len);
        r.best = umax(r.best, umax(r.lead, r.trail));
      end
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] pack_node(run_t r);
    return {r.first, r.last, r.lead, r.trail, r.best};
  endfunction

  state_e         state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           built_q, built_d;
  logic [CW-1:0]  ql_q, ql_d, qr_q, qr_d;
  run_t           acc_q, acc_d, lhs_q, lhs_d;
  frame_t         cur_q, cur_d;
  logic [SPW-1:0] sp_q, sp_d;
  out_item_t      res_q, res_d;
  logic           res_v_q, res_v_d;
  in_item_t       item_q;

  frame_t         stk [SD];
  logic           stk_we;
  logic [SPW-1:0] stk_wa;
  frame_t         stk_wd;
  frame_t         stk_rd;
  logic [SPW-1:0] top_idx;

  logic                   elem_we;
  logic [LW-1:0]          elem_wa, elem_ra;
  logic [VALUE_WIDTH-1:0] elem_mem [MAX_ELEMENTS];
  logic [VALUE_WIDTH-1:0] elem_wd, elem_rd;

  logic          nm_we;
  logic [NW-1:0] nm_wa, nm_ra;
  logic [DW-1:0] nm_wd, nm_rd;
  run_t          nm_run;

  logic [CW-1:0] load_base, mid, top_mid;
  logic          is_leaf, full_in, disjoint, q_ok;
  logic [NW-1:0] lchild, rchild;
  frame_t        right_frame;
  run_t          leaf_run, node_run, rchild_run, cmb;

  rmfrq_node_mem #(.AddrWidth(NW), .DataWidth(DW)) u_node_mem (
    .clk_i  (clk_i),
    .we_i   (nm_we),
    .waddr_i(nm_wa),
    .wdata_i(nm_wd),
    .raddr_i(nm_ra),
    .rdata_o(nm_rd)
  );

  assign elem_wd = VALUE_WIDTH'($unsigned(item_q.value));

  always_ff @(posedge clk_i) begin
    if (elem_we) elem_mem[elem_wa] <= elem_wd;
    elem_rd <= elem_mem[elem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk[stk_wa] <= stk_wd;
  end
  assign top_idx = sp_q - SPW'(1);
  assign stk_rd  = stk[top_idx];

  always_comb begin
    nm_run       = '0;
    nm_run.first = nm_rd[DW-1 -: VALUE_WIDTH];
    nm_run.last  = nm_rd[DW-VALUE_WIDTH-1 -: VALUE_WIDTH];
    nm_run.lead  = nm_rd[3*CW-1 -: CW];
    nm_run.trail = nm_rd[2*CW-1 -: CW];
    nm_run.best  = nm_rd[CW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) item_q <= in_data_i;
  end

  assign in_ready_o  = (state_q == StIdle) && !res_v_q;
  assign out_valid_o = res_v_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      built_q <= 1'b0;
      res_v_q <= 1'b0;
      sp_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      built_q <= built_d;
      res_v_q <= res_v_d;
      sp_q    <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ql_q  <= ql_d;
    qr_q  <= qr_d;
    acc_q <= acc_d;
    lhs_q <= lhs_d;
    cur_q <= cur_d;
    res_q <= res_d;
  end

  assign load_base = built_q ? '0 : cnt_q;
  assign mid       = cur_q.lo + ((cur_q.hi - cur_q.lo) >> 1);
  assign is_leaf   = (cur_q.lo == cur_q.hi);
  assign lchild    = {cur_q.node[NW-2:0], 1'b0};
  assign rchild    = {cur_q.node[NW-2:0], 1'b1};
  assign full_in   = (ql_q <= cur_q.lo) && (cur_q.hi <= qr_q);
  assign disjoint  = (qr_q < cur_q.lo) || (ql_q > cur_q.hi);
  assign q_ok      = built_q && (in_data_i.left_index <= in_data_i.right_index) &&
                     (32'(in_data_i.right_index) < 32'(cnt_q));

  // right child of the frame on top of the stack
  assign top_mid = stk_rd.lo + ((stk_rd.hi - stk_rd.lo) >> 1);
  always_comb begin
    right_frame.node = {stk_rd.node[NW-2:0], 1'b1};
    right_frame.lo   = top_mid + CW'(1);
    right_frame.hi   = stk_rd.hi;
    right_frame.post = 1'b0;
  end

  always_comb begin
    leaf_run       = '0;
    leaf_run.first = elem_rd;
    leaf_run.last  = elem_rd;
    leaf_run.span  = CW'(1);
    leaf_run.lead  = CW'(1);
    leaf_run.trail = CW'(1);
    leaf_run.best  = CW'(1);
  end

  always_comb begin
    node_run      = nm_run;
    node_run.span = cur_q.hi - cur_q.lo + CW'(1);
  end

  // lhs_q holds the left child, nm_run the right child
  always_comb begin
    rchild_run      = nm_run;
    rchild_run.span = cur_q.hi - mid;
  end
  assign cmb = combine(lhs_q, rchild_run);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    built_d = built_q;
    res_v_d = res_v_q;
    res_d   = res_q;
    sp_d    = sp_q;
    ql_d    = ql_q;
    qr_d    = qr_q;
    acc_d   = acc_q;
    lhs_d   = lhs_q;
    cur_d   = cur_q;
    stk_we  = 1'b0;
    stk_wa  = sp_q;
    stk_wd  = cur_q;
    elem_we = 1'b0;
    elem_wa = load_base[LW-1:0];
    elem_ra = cur_q.lo[LW-1:0];
    nm_we   = 1'b0;
    nm_wa   = cur_q.node;
    nm_wd   = pack_node(leaf_run);
    nm_ra   = cur_q.node;

    if (res_v_q && out_ready_i) res_v_d = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          if (in_data_i.func == FuncLoad) begin
            state_d = StLoad;
          end else begin
            ql_d = CW'(in_data_i.left_index);
            qr_d = CW'(in_data_i.right_index);
            if (q_ok) begin
              acc_d       = '0;
              acc_d.empty = 1'b1;
              cur_d.node  = NW'(1);
              cur_d.lo    = '0;
              cur_d.hi    = cnt_q - CW'(1);
              cur_d.post  = 1'b0;
              sp_d        = '0;
              state_d     = StQWalk;
            end else begin
              res_d   = '0;
              res_v_d = 1'b1;
            end
          end
        end
      end
      StLoad: begin
        built_d = 1'b0;
        cnt_d   = load_base;
        if (load_base < CW'(MAX_ELEMENTS)) begin
          elem_we = 1'b1;
          cnt_d   = load_base + CW'(1);
        end
        if (item_q.last) begin
          cur_d.node = NW'(1);
          cur_d.lo   = '0;
          cur_d.hi   = cnt_d - CW'(1);
          cur_d.post = 1'b0;
          sp_d       = '0;
          state_d    = StBWalk;
        end else begin
          state_d = StIdle;
        end
      end
      StBWalk: begin
        if (is_leaf) begin
          state_d = StBLeaf;
        end else begin
          stk_we      = 1'b1;
          stk_wd.post = 1'b0;
          sp_d        = sp_q + SPW'(1);
          cur_d.node  = lchild;
          cur_d.hi    = mid;
          cur_d.post  = 1'b0;
        end
      end
      StBLeaf: begin
        nm_we   = 1'b1;
        nm_wd   = pack_node(leaf_run);
        state_d = StBRet;
      end
      StBRet: begin
        if (sp_q == '0) begin
          built_d = 1'b1;
          state_d = StIdle;
        end else if (!stk_rd.post) begin
          stk_we      = 1'b1;
          stk_wa      = top_idx;
          stk_wd      = stk_rd;
          stk_wd.post = 1'b1;
          cur_d       = right_frame;
          state_d     = StBWalk;
        end else begin
          cur_d   = stk_rd;
          sp_d    = top_idx;
          state_d = StBRdL;
        end
      end
      StBRdL: begin
        nm_ra   = lchild;
        state_d = StBRdR;
      end
      StBRdR: begin
        lhs_d      = nm_run;
        lhs_d.span = mid - cur_q.lo + CW'(1);
        nm_ra      = rchild;
        state_d    = StBWr;
      end
      StBWr: begin
        nm_we   = 1'b1;
        nm_wd   = pack_node(cmb);
        state_d = StBRet;
      end
      StQWalk: begin
        nm_ra = cur_q.node;
        if (disjoint) begin
          state_d = StQRet;
        end else if (full_in) begin
          state_d = StQMerge;
        end else begin
          stk_we      = 1'b1;
          stk_wd.post = 1'b0;
          sp_d        = sp_q + SPW'(1);
          cur_d.node  = lchild;
          cur_d.hi    = mid;
          cur_d.post  = 1'b0;
        end
      end
      StQMerge: begin
        acc_d   = combine(acc_q, node_run);
        state_d = StQRet;
      end
      StQRet: begin
        if (sp_q == '0) begin
          res_d.max_frequency = OutRunWidth'(acc_q.best);
          res_d.valid_res     = 1'b1;
          res_v_d             = 1'b1;
          state_d             = StIdle;
        end else if (!stk_rd.post) begin
          stk_we      = 1'b1;
          stk_wa      = top_idx;
          stk_wd      = stk_rd;
          stk_wd.post = 1'b1;
          cur_d       = right_frame;
          state_d     = StQWalk;
        end else begin
          sp_d = top_idx;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

// ----- hdl/rmfrq_node_mem.sv -----
// ----------------------------------------------------------------------------
// rmfrq_node_mem
// Node memory of the tree: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rmfrq_node_mem #(
  parameter int unsigned AddrWidth = 18,
  parameter int unsigned DataWidth = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [DataWidth-1:0] wdata_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [DataWidth-1:0] rdata_o
);

  logic [DataWidth-1:0] mem [2**AddrWidth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- hdl/rmfrq_checker.sv -----
// ----------------------------------------------------------------------------
// rmfrq_checker
// Port-level checks of the range query block.
// ----------------------------------------------------------------------------
module rmfrq_checker
  import rmfrq_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped while stalled");

  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while result pending");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.func == FuncLoad) |=> !out_valid_o)
    else $error("load produced a transfer");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.valid_res |-> out_data_o.max_frequency == '0)
    else $error("invalid result not zero");

endmodule

bind range_most_frequent_run_query_top rmfrq_checker u_rmfrq_checker (.*);
